// ----- design/assert_macros.svh -----
// Assertion macros for the top level of the program sequence initializer.
// Depends on nothing; assertions drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- design/psis_pkg.sv -----
// Constants and types for the program sequence initializer.
// Used by psis_mod and program_sequence_init_shuffle; depends on nothing.
package psis_pkg;

    localparam int WORD_W = 32;
    localparam int SEED_W = 64;
    localparam int SLOT_W = 4;
    localparam int DIV_W  = 5;
    localparam int CHUNK_W = 8;

    localparam logic [WORD_W-1:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [WORD_W-1:0] FNV_PRIME = 32'h01000193;
    localparam logic [WORD_W-1:0] MWC_Z_MUL = 32'd36969;
    localparam logic [WORD_W-1:0] MWC_W_MUL = 32'd18000;
    localparam logic [WORD_W-1:0] LCG_MUL   = 32'd69069;
    localparam logic [WORD_W-1:0] LCG_INC   = 32'd1234567;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [DIV_W-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] rem;
    } mod_rsp_t;

endpackage

// ----- design/psis_mod.sv -----
// Iterative remainder unit: 32-bit word modulo a small divisor, one byte per cycle.
// Depends on psis_pkg.
module psis_mod (
    input  logic               aclk,
    input  logic               aresetn,
    input  psis_pkg::mod_req_t req,
    output psis_pkg::mod_rsp_t rsp
);

    localparam int NCHUNK = psis_pkg::WORD_W / psis_pkg::CHUNK_W;

    logic                          busy_reg;
    logic                          done_reg;
    logic [$clog2(NCHUNK)-1:0]     cnt_reg;
    logic [psis_pkg::WORD_W-1:0]   num_reg;
    logic [psis_pkg::DIV_W-1:0]    div_reg;
    logic [psis_pkg::DIV_W-1:0]    rem_reg;
    logic [psis_pkg::DIV_W-1:0]    rem_next;

    always_comb begin
        logic [psis_pkg::DIV_W-1:0]   r;
        logic [psis_pkg::CHUNK_W-1:0] chunk;
        r     = rem_reg;
        chunk = num_reg[psis_pkg::WORD_W-1 -: psis_pkg::CHUNK_W];
        for (int b = psis_pkg::CHUNK_W - 1; b >= 0; b--) begin
            r = {r[psis_pkg::DIV_W-2:0], chunk[b]};
            if (r >= div_reg) begin
                r = r - div_reg;
            end
        end
        rem_next = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= req.dividend;
                div_reg  <= req.divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                num_reg <= num_reg << psis_pkg::CHUNK_W;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == $clog2(NCHUNK)'(NCHUNK - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg[psis_pkg::SLOT_W-1:0];

endmodule

// ----- design/program_sequence_init_shuffle.sv -----
// Top level: seeds KISS99 from a 64-bit seed, shuffles the slot memory, streams it out.
// Depends on psis_pkg, psis_mod and assert_macros.svh.
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | s_program_seed
//  m_      | out       | m_valid / m_ready | m_slot_position .. m_rng_jcong
//
// One seed at a time: seeding, filling all NUM_SLOTS slots, then NUM_SLOTS-1 draws, each
// paced by the byte-serial remainder unit and the single memory port, then one memory
// read per result; the next request is taken once the last result has been loaded.
// Reset clears the sequencer and the result valid; nothing carries between seeds.
// A stalled result holds; the next seed is taken while the last result waits.
`include "assert_macros.svh"

module program_sequence_init_shuffle #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [psis_pkg::SEED_W-1:0]   s_program_seed,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [psis_pkg::SLOT_W-1:0]   m_slot_position,
    output logic [psis_pkg::SLOT_W-1:0]   m_slot_destination,
    output logic                          m_last_slot,
    output logic [psis_pkg::WORD_W-1:0]   m_rng_z,
    output logic [psis_pkg::WORD_W-1:0]   m_rng_w,
    output logic [psis_pkg::WORD_W-1:0]   m_rng_jsr,
    output logic [psis_pkg::WORD_W-1:0]   m_rng_jcong
);

    localparam int AW = $clog2(NUM_SLOTS);
    localparam logic [AW-1:0] LAST = AW'(NUM_SLOTS - 1);
    localparam logic [psis_pkg::SLOT_W-1:0] LAST_POS = psis_pkg::SLOT_W'(NUM_SLOTS - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SEED, ST_FILL, ST_DRAW, ST_MIX,
        ST_MOD, ST_WRI, ST_WRJ, ST_OUT_RD, ST_OUT_LD
    } state_t;

    state_t                         state_reg;
    logic [1:0]                     step_reg;
    logic [AW-1:0]                  k_reg;
    logic [AW-1:0]                  idx_reg;
    logic [AW-1:0]                  j_reg;
    logic [psis_pkg::SEED_W-1:0]    seed_reg;
    logic [psis_pkg::WORD_W-1:0]    h_reg;
    logic [psis_pkg::WORD_W-1:0]    z_reg, w_reg, jsr_reg, jc_reg;
    logic [psis_pkg::SLOT_W-1:0]    val_i_reg;
    logic [psis_pkg::SLOT_W-1:0]    rd_data_reg;

    logic                           m_valid_reg;
    logic [psis_pkg::SLOT_W-1:0]    pos_reg, dest_reg;
    logic                           last_reg;
    logic [psis_pkg::WORD_W-1:0]    oz_reg, ow_reg, ojsr_reg, ojc_reg;

    logic [psis_pkg::SLOT_W-1:0]    seq_mem [NUM_SLOTS];
    logic                           mem_we, mem_re;
    logic [AW-1:0]                  mem_wa, mem_ra;
    logic [psis_pkg::SLOT_W-1:0]    mem_wd;

    logic [psis_pkg::WORD_W-1:0]    fnv_h;
    logic [psis_pkg::WORD_W-1:0]    z_next, w_next, jsr_next, jc_next;
    logic [psis_pkg::WORD_W-1:0]    jsr_a, jsr_b, draw_word;

    psis_pkg::mod_req_t             mod_req;
    psis_pkg::mod_rsp_t             mod_rsp;

    psis_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    // FNV-1a fold: basis on the first step, low and high words alternate
    always_comb begin
        logic [psis_pkg::WORD_W-1:0] h_in;
        logic [psis_pkg::WORD_W-1:0] d_in;
        h_in  = (step_reg == 2'd0) ? psis_pkg::FNV_BASIS : h_reg;
        d_in  = step_reg[0] ? seed_reg[63:32] : seed_reg[31:0];
        fnv_h = (h_in ^ d_in) * psis_pkg::FNV_PRIME;
    end

    // KISS99 word update
    assign z_next   = (psis_pkg::MWC_Z_MUL * {16'd0, z_reg[15:0]}) + {16'd0, z_reg[31:16]};
    assign w_next   = (psis_pkg::MWC_W_MUL * {16'd0, w_reg[15:0]}) + {16'd0, w_reg[31:16]};
    assign jsr_a    = jsr_reg ^ (jsr_reg << 17);
    assign jsr_b    = jsr_a ^ (jsr_a >> 13);
    assign jsr_next = jsr_b ^ (jsr_b << 5);
    assign jc_next  = (psis_pkg::LCG_MUL * jc_reg) + psis_pkg::LCG_INC;

    // draw output from the updated words
    assign draw_word = (({z_reg[15:0], 16'd0} + w_reg) ^ jc_reg) + jsr_reg;

    always_comb begin
        mod_req.start    = (state_reg == ST_MIX);
        mod_req.dividend = draw_word;
        mod_req.divisor  = psis_pkg::DIV_W'(idx_reg) + 1'b1;
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = '0;
        unique case (state_reg)
            ST_FILL: begin
                mem_we = 1'b1;
                mem_wa = k_reg;
                mem_wd = psis_pkg::SLOT_W'(k_reg);
            end
            ST_DRAW: begin
                mem_re = 1'b1;
                mem_ra = idx_reg;
            end
            ST_MOD: begin
                mem_re = mod_rsp.done;
                mem_ra = mod_rsp.rem[AW-1:0];
            end
            ST_WRI: begin
                mem_we = 1'b1;
                mem_wa = idx_reg;
                mem_wd = rd_data_reg;
            end
            ST_WRJ: begin
                mem_we = 1'b1;
                mem_wa = j_reg;
                mem_wd = val_i_reg;
            end
            ST_OUT_RD: begin
                mem_re = 1'b1;
                mem_ra = k_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            seq_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= seq_mem[mem_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_OUT_LD)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        seed_reg  <= s_program_seed;
                        step_reg  <= 2'd0;
                        state_reg <= ST_SEED;
                    end
                end
                ST_SEED: begin
                    h_reg <= fnv_h;
                    case (step_reg)
                        2'd0: z_reg   <= fnv_h;
                        2'd1: w_reg   <= fnv_h;
                        2'd2: jsr_reg <= fnv_h;
                        2'd3: jc_reg  <= fnv_h;
                        default: z_reg <= fnv_h;
                    endcase
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3) begin
                        k_reg     <= '0;
                        state_reg <= ST_FILL;
                    end
                end
                ST_FILL: begin
                    if (k_reg == LAST) begin
                        idx_reg   <= LAST;
                        state_reg <= ST_DRAW;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_DRAW: begin
                    z_reg     <= z_next;
                    w_reg     <= w_next;
                    jsr_reg   <= jsr_next;
                    jc_reg    <= jc_next;
                    state_reg <= ST_MIX;
                end
                ST_MIX: begin
                    val_i_reg <= rd_data_reg;
                    state_reg <= ST_MOD;
                end
                ST_MOD: begin
                    if (mod_rsp.done) begin
                        j_reg     <= mod_rsp.rem[AW-1:0];
                        state_reg <= ST_WRI;
                    end
                end
                ST_WRI: begin
                    state_reg <= ST_WRJ;
                end
                ST_WRJ: begin
                    if (idx_reg == AW'(1)) begin
                        idx_reg   <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_OUT_RD;
                    end else begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= ST_DRAW;
                    end
                end
                ST_OUT_RD: begin
                    state_reg <= ST_OUT_LD;
                end
                ST_OUT_LD: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        pos_reg     <= psis_pkg::SLOT_W'(k_reg);
                        dest_reg    <= rd_data_reg;
                        last_reg    <= (k_reg == LAST);
                        oz_reg      <= z_reg;
                        ow_reg      <= w_reg;
                        ojsr_reg    <= jsr_reg;
                        ojc_reg     <= jc_reg;
                        if (k_reg == LAST) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_OUT_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_slot_position    = pos_reg;
    assign m_slot_destination = dest_reg;
    assign m_last_slot        = last_reg;
    assign m_rng_z            = oz_reg;
    assign m_rng_w            = ow_reg;
    assign m_rng_jsr          = ojsr_reg;
    assign m_rng_jcong        = ojc_reg;

    `ASSERT_CLK(a_done_in_mod, aclk, aresetn, !mod_rsp.done || (state_reg == ST_MOD))
    `ASSERT_CLK(a_idx_range, aclk, aresetn, idx_reg <= LAST)
    `ASSERT_CLK(a_last_pos, aclk, aresetn, !(m_valid && m_last_slot) || (m_slot_position == LAST_POS))
    `ASSERT_NEXT(a_accept_seeds, aclk, aresetn, s_valid && s_ready, state_reg == ST_SEED)

endmodule

// ----- test/program_sequence_init_shuffle_test.sv -----
// Self-checking bench for program_sequence_init_shuffle: seeds go in, and every slot result
// is checked against a KISS99 seeding and Fisher-Yates shuffle computed in the bench itself.
// Depends on psis_pkg and the program_sequence_init_shuffle RTL.
module program_sequence_init_shuffle_test;
    import psis_pkg::*;

    localparam int SLOT_COUNT  = 16;
    localparam int HOLD_CYCLES = 600;
    localparam int RANDOM_SEEDS = 416;

    typedef struct packed {
        logic [SLOT_W-1:0] position;
        logic [SLOT_W-1:0] destination;
        logic              last;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] jsr;
        logic [WORD_W-1:0] jcong;
    } slot_result_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [SEED_W-1:0]   s_program_seed = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [SLOT_W-1:0]   m_slot_position;
    logic [SLOT_W-1:0]   m_slot_destination;
    logic                m_last_slot;
    logic [WORD_W-1:0]   m_rng_z;
    logic [WORD_W-1:0]   m_rng_w;
    logic [WORD_W-1:0]   m_rng_jsr;
    logic [WORD_W-1:0]   m_rng_jcong;

    logic [SEED_W-1:0]   pending_seeds[$];
    slot_result_t        expected_slots[$];

    logic s_taken = 1'b0;
    logic m_taken = 1'b0;
    logic hold_results = 1'b0;
    logic steady_send = 1'b0;
    logic steady_recv = 1'b0;
    int   send_wait = 0;
    int   recv_wait = 0;
    int   seeds_taken = 0;
    int   slots_checked = 0;
    int   mismatches = 0;
    int   input_stall_cycles = 0;

    program_sequence_init_shuffle #(
        .NUM_SLOTS(SLOT_COUNT)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_program_seed(s_program_seed),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_slot_position(m_slot_position),
        .m_slot_destination(m_slot_destination),
        .m_last_slot(m_last_slot),
        .m_rng_z(m_rng_z),
        .m_rng_w(m_rng_w),
        .m_rng_jsr(m_rng_jsr),
        .m_rng_jcong(m_rng_jcong)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic void predict_sequence(input logic [SEED_W-1:0] seed);
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] h;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] jsr;
        logic [WORD_W-1:0] jc;
        logic [WORD_W-1:0] mwc;
        logic [WORD_W-1:0] draw;
        logic [SLOT_W-1:0] slots[16];
        logic [SLOT_W-1:0] t;
        logic [SLOT_W-1:0] j;
        slot_result_t      r;
        lo = seed[31:0];
        hi = seed[63:32];
        h = FNV_BASIS;
        h = (h ^ lo) * FNV_PRIME;
        z = h;
        h = (h ^ hi) * FNV_PRIME;
        w = h;
        h = (h ^ lo) * FNV_PRIME;
        jsr = h;
        h = (h ^ hi) * FNV_PRIME;
        jc = h;
        for (int k = 0; k < 16; k++) begin
            slots[SLOT_W'(k)] = SLOT_W'(k);
        end
        for (int i = SLOT_COUNT - 1; i > 0; i--) begin
            z = MWC_Z_MUL * {16'h0000, z[15:0]} + (z >> 16);
            w = MWC_W_MUL * {16'h0000, w[15:0]} + (w >> 16);
            mwc = (z << 16) + w;
            jsr = jsr ^ (jsr << 17);
            jsr = jsr ^ (jsr >> 13);
            jsr = jsr ^ (jsr << 5);
            jc = LCG_MUL * jc + LCG_INC;
            draw = (mwc ^ jc) + jsr;
            j = SLOT_W'(draw % WORD_W'(i + 1));
            t = slots[SLOT_W'(i)];
            slots[SLOT_W'(i)] = slots[j];
            slots[j] = t;
        end
        for (int k = 0; k < SLOT_COUNT; k++) begin
            r.position = SLOT_W'(k);
            r.destination = slots[SLOT_W'(k)];
            r.last = (k == SLOT_COUNT - 1);
            r.z = z;
            r.w = w;
            r.jsr = jsr;
            r.jcong = jc;
            expected_slots.push_back(r);
        end
    endfunction

    // Sample both handshakes and check results at the rising edge.
    always @(posedge aclk) begin
        slot_result_t got;
        slot_result_t exp_slot;
        s_taken <= aresetn && s_valid && s_ready;
        m_taken <= aresetn && m_valid && m_ready;
        if (aresetn && hold_results && s_valid && !s_ready) begin
            input_stall_cycles++;
        end
        if (aresetn && s_valid && s_ready) begin
            predict_sequence(s_program_seed);
            seeds_taken++;
        end
        if (aresetn && m_valid && m_ready) begin
            got = '{m_slot_position, m_slot_destination, m_last_slot,
                    m_rng_z, m_rng_w, m_rng_jsr, m_rng_jcong};
            if (expected_slots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: pos %0d dest %0d last %0b",
                             got.position, got.destination, got.last);
                end
            end else begin
                exp_slot = expected_slots.pop_front();
                slots_checked++;
                if (got !== exp_slot) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at slot %0d: exp pos %0d dest %0d last %0b",
                                 slots_checked - 1, exp_slot.position,
                                 exp_slot.destination, exp_slot.last);
                        $display("  got pos %0d dest %0d last %0b", got.position,
                                 got.destination, got.last);
                        $display("  exp rng %h %h %h %h", exp_slot.z, exp_slot.w,
                                 exp_slot.jsr, exp_slot.jcong);
                        $display("  got rng %h %h %h %h", got.z, got.w, got.jsr,
                                 got.jcong);
                    end
                end
            end
        end
    end

    // Offer seeds from the pending queue with a random gap per request, none in steady stretches.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_taken)) begin
            if (s_valid) begin
                if ($urandom_range(0, 7) == 0) begin
                    steady_send = !steady_send;
                end
                send_wait = steady_send ? 0 : $urandom_range(0, 9);
            end
            if (send_wait > 0 || pending_seeds.size() == 0) begin
                if (send_wait > 0) begin
                    send_wait--;
                end
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_program_seed <= pending_seeds.pop_front();
            end
        end
    end

    // Accept results with a random pause after each one (none in steady stretches) unless held.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_taken) begin
                if (m_last_slot && $urandom_range(0, 3) == 0) begin
                    steady_recv = !steady_recv;
                end
                recv_wait = steady_recv ? 0 : $urandom_range(0, 9);
            end
            if (hold_results || recv_wait > 0) begin
                if (recv_wait > 0) begin
                    recv_wait--;
                end
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Hold off the result side long enough for the input to back up.
    initial begin
        wait (seeds_taken >= 20);
        @(posedge aclk);
        hold_results = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_results = 1'b0;
    end

    initial begin
        #20000000;
        $display("program_sequence_init_shuffle_test NOT OK");
        $finish;
    end

    initial begin
        pending_seeds.push_back(64'h0000_0000_0000_0000);
        pending_seeds.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        pending_seeds.push_back(64'h0000_0000_FFFF_FFFF);
        pending_seeds.push_back(64'hFFFF_FFFF_0000_0000);
        pending_seeds.push_back(64'h5555_5555_5555_5555);
        pending_seeds.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        pending_seeds.push_back(64'h0000_0000_0000_0001);
        pending_seeds.push_back(64'h8000_0000_0000_0000);
        pending_seeds.push_back(64'h0000_0001_0000_0001);
        pending_seeds.push_back(64'h0000_0000_8000_0000);
        pending_seeds.push_back({32'h0000_0000, FNV_BASIS});
        pending_seeds.push_back({FNV_BASIS, FNV_BASIS});
        pending_seeds.push_back(64'h0123_4567_89AB_CDEF);
        pending_seeds.push_back(64'h0123_4567_89AB_CDEF);
        for (int n = 0; n < RANDOM_SEEDS; n++) begin
            pending_seeds.push_back({$urandom(), $urandom()});
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (pending_seeds.size() == 0 && !s_valid);
        wait (expected_slots.size() == 0);
        repeat (400) @(posedge aclk);

        $display("%0d seeds, %0d slot results checked, %0d mismatches",
                 seeds_taken, slots_checked, mismatches);
        $display("input held back for %0d cycles while results were stalled",
                 input_stall_cycles);
        if (mismatches == 0) begin
            $display("program_sequence_init_shuffle_test OK");
        end else begin
            $display("program_sequence_init_shuffle_test NOT OK");
        end
        $finish;
    end
endmodule
